### design/msr_pkg.sv
// shared types, constants and helpers for the spiral order matrix reader
`timescale 1ns / 1ps
`default_nettype none
package msr_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int ELEM_W      = 32;
  localparam int CFG_W       = 5;
  localparam int STORE_W     = (DATA_WIDTH > ELEM_W) ? ELEM_W : DATA_WIDTH;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
  localparam int RCNT_W      = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W      = $clog2(MAX_COLS + 1);
  localparam int RIDX_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // register indexes of the configuration port
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // walk directions
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic                     req_type;
    logic signed [ELEM_W-1:0] elem_value;
  } msr_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_value;
    logic                     is_last;
    logic                     status;
  } msr_out_t;

  // controller to datapath
  typedef struct packed {
    logic cfg_we;
    logic load_we;
    logic walk_step;
    logic nr_emit;
    logic rd_emit;
  } msr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic loaded;
    logic out_blocked;
  } msr_sts_t;

  function automatic logic [RCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [RCNT_W-1:0] r;
    if (v == '0) begin
      r = RCNT_W'(1);
    end else if (32'(v) > MAX_ROWS) begin
      r = RCNT_W'(MAX_ROWS);
    end else begin
      r = RCNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [CCNT_W-1:0] c;
    if (v == '0) begin
      c = CCNT_W'(1);
    end else if (32'(v) > MAX_COLS) begin
      c = CCNT_W'(MAX_COLS);
    end else begin
      c = CCNT_W'(v);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/msr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module msr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/msr_ctrl.sv
// controller state machine: request decode and handshakes
`timescale 1ns / 1ps
`default_nettype none
module msr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              req_type_i,
  input  wire logic              cfg_valid_i,
  input  wire msr_pkg::msr_sts_t sts_i,
  output logic                   in_stall_o,
  output logic                   cfg_ready_o,
  output msr_pkg::msr_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o  = (state_q != ST_IDLE) || sts_i.out_blocked;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.cfg_we    = cfg_valid_i && cfg_ready_o;
    cmd_o.load_we   = accept && (req_type_i == msr_pkg::REQ_LOAD);
    cmd_o.walk_step = accept && (req_type_i == msr_pkg::REQ_FETCH) && sts_i.loaded;
    cmd_o.nr_emit   = accept && (req_type_i == msr_pkg::REQ_FETCH) && !sts_i.loaded;
    cmd_o.rd_emit   = (state_q == ST_READ);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.walk_step) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### design/msr_dp.sv
// datapath: config, load pointer, spiral walk, element store and output word
`timescale 1ns / 1ps
`default_nettype none
module msr_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire msr_pkg::msr_cmd_t               cmd_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [msr_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic signed [msr_pkg::ELEM_W-1:0] elem_value_i,
  input  wire logic                            out_stall_i,
  output msr_pkg::msr_sts_t                    sts_o,
  output logic                                 out_valid_o,
  output msr_pkg::msr_out_t                    out_data_o
);

  localparam int TOT_W  = msr_pkg::TOT_W;
  localparam int RCNT_W = msr_pkg::RCNT_W;
  localparam int CCNT_W = msr_pkg::CCNT_W;
  localparam int RIDX_W = msr_pkg::RIDX_W;
  localparam int CIDX_W = msr_pkg::CIDX_W;
  localparam int ADDR_W = msr_pkg::ADDR_W;
  localparam int CFG_W  = msr_pkg::CFG_W;

  logic [CFG_W-1:0]  row_cfg_q, row_cfg_d, col_cfg_q, col_cfg_d;
  logic [TOT_W-1:0]  load_ptr_q, load_ptr_d, emitted_q, emitted_d;
  logic [RCNT_W-1:0] top_q, top_d, bottom_q, bottom_d;
  logic [CCNT_W-1:0] left_q, left_d, right_q, right_d;
  logic [RIDX_W-1:0] cur_row_q, cur_row_d;
  logic [CIDX_W-1:0] cur_col_q, cur_col_d;
  logic [1:0]        dir_q, dir_d;
  logic              last_q;
  logic              out_valid_q;
  msr_pkg::msr_out_t out_q;

  logic [RCNT_W-1:0] rows, rows_new;
  logic [CCNT_W-1:0] cols, cols_new;
  logic [TOT_W-1:0]  total, idx;
  logic              loaded, last, rearm;
  logic [msr_pkg::STORE_W-1:0] rd_data;
  logic signed [msr_pkg::STORE_W-1:0] rd_signed;

  assign rows  = msr_pkg::clamp_rows(row_cfg_q);
  assign cols  = msr_pkg::clamp_cols(col_cfg_q);
  assign total = TOT_W'(rows) * TOT_W'(cols);
  assign idx   = TOT_W'(cur_row_q) * TOT_W'(cols) + TOT_W'(cur_col_q);

  assign loaded = (load_ptr_q >= total);
  assign last   = ((emitted_q + TOT_W'(1)) >= total);

  assign sts_o.loaded      = loaded;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  // new config values, so a write rearms with the geometry it sets
  always_comb begin
    row_cfg_d = row_cfg_q;
    col_cfg_d = col_cfg_q;
    if (cmd_i.cfg_we) begin
      unique case (cfg_idx_i)
        msr_pkg::REG_ROW_COUNT: row_cfg_d = cfg_data_i;
        msr_pkg::REG_COL_COUNT: col_cfg_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_new = msr_pkg::clamp_rows(row_cfg_d);
  assign cols_new = msr_pkg::clamp_cols(col_cfg_d);
  assign rearm    = cmd_i.cfg_we || (cmd_i.walk_step && last);

  always_comb begin
    load_ptr_d = load_ptr_q;
    emitted_d  = emitted_q;
    top_d      = top_q;
    bottom_d   = bottom_q;
    left_d     = left_q;
    right_d    = right_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    dir_d      = dir_q;
    if (rearm) begin
      load_ptr_d = '0;
      emitted_d  = '0;
      top_d      = '0;
      bottom_d   = rows_new - RCNT_W'(1);
      left_d     = '0;
      right_d    = cols_new - CCNT_W'(1);
      cur_row_d  = '0;
      cur_col_d  = '0;
      dir_d      = msr_pkg::DIR_RIGHT;
    end else if (cmd_i.load_we) begin
      if (!loaded) begin
        load_ptr_d = load_ptr_q + TOT_W'(1);
      end
    end else if (cmd_i.walk_step) begin
      emitted_d = emitted_q + TOT_W'(1);
      unique case (dir_q)
        msr_pkg::DIR_RIGHT: begin
          if (CCNT_W'(cur_col_q) < right_q) begin
            cur_col_d = cur_col_q + CIDX_W'(1);
          end else begin
            top_d     = top_q + RCNT_W'(1);
            dir_d     = msr_pkg::DIR_DOWN;
            cur_row_d = cur_row_q + RIDX_W'(1);
          end
        end
        msr_pkg::DIR_DOWN: begin
          if (RCNT_W'(cur_row_q) < bottom_q) begin
            cur_row_d = cur_row_q + RIDX_W'(1);
          end else begin
            if (right_q != '0) right_d = right_q - CCNT_W'(1);
            dir_d = msr_pkg::DIR_LEFT;
            if (cur_col_q != '0) cur_col_d = cur_col_q - CIDX_W'(1);
          end
        end
        msr_pkg::DIR_LEFT: begin
          if (CCNT_W'(cur_col_q) > left_q) begin
            cur_col_d = cur_col_q - CIDX_W'(1);
          end else begin
            if (bottom_q != '0) bottom_d = bottom_q - RCNT_W'(1);
            dir_d = msr_pkg::DIR_UP;
            if (cur_row_q != '0) cur_row_d = cur_row_q - RIDX_W'(1);
          end
        end
        msr_pkg::DIR_UP: begin
          if (RCNT_W'(cur_row_q) > top_q) begin
            cur_row_d = cur_row_q - RIDX_W'(1);
          end else begin
            left_d    = left_q + CCNT_W'(1);
            dir_d     = msr_pkg::DIR_RIGHT;
            cur_col_d = cur_col_q + CIDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q   <= msr_pkg::CFG_RESET;
      col_cfg_q   <= msr_pkg::CFG_RESET;
      load_ptr_q  <= '0;
      emitted_q   <= '0;
      top_q       <= '0;
      bottom_q    <= msr_pkg::clamp_rows(msr_pkg::CFG_RESET) - RCNT_W'(1);
      left_q      <= '0;
      right_q     <= msr_pkg::clamp_cols(msr_pkg::CFG_RESET) - CCNT_W'(1);
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      dir_q       <= msr_pkg::DIR_RIGHT;
      out_valid_q <= 1'b0;
    end else begin
      row_cfg_q  <= row_cfg_d;
      col_cfg_q  <= col_cfg_d;
      load_ptr_q <= load_ptr_d;
      emitted_q  <= emitted_d;
      top_q      <= top_d;
      bottom_q   <= bottom_d;
      left_q     <= left_d;
      right_q    <= right_d;
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      dir_q      <= dir_d;
      if (cmd_i.nr_emit || cmd_i.rd_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rd_signed = rd_data;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      last_q <= last;
    end
    if (cmd_i.nr_emit) begin
      out_q.out_value <= '0;
      out_q.is_last   <= 1'b0;
      out_q.status    <= 1'b1;
    end else if (cmd_i.rd_emit) begin
      out_q.out_value <= msr_pkg::ELEM_W'(rd_signed);
      out_q.is_last   <= last_q;
      out_q.status    <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  msr_ram #(
    .WIDTH (msr_pkg::STORE_W),
    .DEPTH (msr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we && !loaded && !cmd_i.cfg_we),
    .waddr_i (load_ptr_q[ADDR_W-1:0]),
    .wdata_i (elem_value_i[msr_pkg::STORE_W-1:0]),
    .re_i    (cmd_i.walk_step),
    .raddr_i (idx[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

endmodule
`default_nettype wire

### design/matrix_spiral_order_reader.sv
// top level of the spiral order matrix reader
//
//  channel  | handshake           | word
//  ---------+---------------------+--------------------------------------
//  in       | in_valid_i/in_stall_o   | msr_in_t: req_type, elem_value
//  out      | out_valid_o/out_stall_i | msr_out_t: out_value, is_last, status
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_idx_i (0 rows, 1 cols), cfg_data_i
//
// a load word is taken when the input is not stalled; the next word can follow right after it unless the input stalls
// a fetch of a loaded matrix passes through the controller's read state, since the element store
// has a registered read port
// a fetch before loading is done returns a status word directly
// reset clears config to 16 x 16 and rearms the load pointer and the walk
// a stalled output word holds; the input stalls while that word is stalled or during the read
`timescale 1ns / 1ps
`default_nettype none
module matrix_spiral_order_reader (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input words
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire msr_pkg::msr_in_t          in_data_i,
  // result words
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output msr_pkg::msr_out_t              out_data_o,
  // configuration writes
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_idx_i,
  input  wire logic [msr_pkg::CFG_W-1:0] cfg_data_i
);

  msr_pkg::msr_cmd_t cmd;
  msr_pkg::msr_sts_t sts;

  // request decode, handshakes and the read sequencing
  msr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // config, pointers, walk bounds, element store, output register
  msr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .elem_value_i (in_data_i.elem_value),
    .out_stall_i  (out_stall_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  // a store read is always followed by the output load in the following cycle
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_step |=> cmd.rd_emit)
    else $error("store read not followed by output load");

  // the output register is free when read data arrives
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_emit |-> !out_valid_o)
    else $error("read data would overwrite a pending word");

  // a not-ready fetch gives a status word with zero payload next cycle
  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.nr_emit |=> (out_valid_o && out_data_o.status && !out_data_o.is_last
                     && (out_data_o.out_value == '0)))
    else $error("not-ready word malformed");

  // a config write and an accepted input never coincide with a read
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_emit |-> (!cmd.cfg_we && !cmd.load_we && !cmd.walk_step))
    else $error("activity during store read");

endmodule
`default_nettype wire
